// File: design/c3lbf_pkg.sv
// Shared constants, register codes and types of the 3x3 line-buffer filter.
`timescale 1ns / 1ps
package c3lbf_pkg;

	localparam int MAX_COLS    = 128;
	localparam int PIXEL_WIDTH = 16;
	localparam int COEF_BITS   = 16;
	localparam int MAX_ROWS    = 4096;

	localparam int ROWS_W     = 13;
	localparam int COLS_W     = 8;
	localparam int KROW_W     = 48;
	localparam int ROW_CNT_W  = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [ROWS_W-1:0] FRAME_ROWS_RESET = ROWS_W'(128);
	localparam logic [COLS_W-1:0] FRAME_COLS_RESET = COLS_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_ROWS    = 3'd0,
		REG_FRAME_COLS    = 3'd1,
		REG_KERNEL_TOP    = 3'd2,
		REG_KERNEL_MIDDLE = 3'd3,
		REG_KERNEL_BOTTOM = 3'd4
	} cfg_reg_t;

endpackage

// File: design/c3lbf_pixel_if.sv
// Pixel input channel: valid/ready handshake carrying one pixel.
`timescale 1ns / 1ps
interface c3lbf_pixel_if #(
	parameter int PIXEL_WIDTH = c3lbf_pkg::PIXEL_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [PIXEL_WIDTH-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

// File: design/c3lbf_result_if.sv
// Result output channel: valid/ready handshake carrying one filtered pixel and its flags.
`timescale 1ns / 1ps
interface c3lbf_result_if #(
	parameter int PIXEL_WIDTH = c3lbf_pkg::PIXEL_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [PIXEL_WIDTH-1:0] filtered;
	logic                          row_end;
	logic                          frame_end;

	modport source (output valid, output filtered, output row_end, output frame_end,
		input ready);
	modport sink (input valid, input filtered, input row_end, input frame_end,
		output ready);
endinterface

// File: design/c3lbf_line_store.sv
// Dual line store: one memory word per column holding the two previous rows, with write forwarding.
`timescale 1ns / 1ps
module c3lbf_line_store #(
	parameter int DEPTH = c3lbf_pkg::MAX_COLS,
	parameter int WIDTH = 2 * c3lbf_pkg::PIXEL_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [WIDTH-1:0] byp_data_q;
	logic             byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// A read of the column being written in the same cycle must see the new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;
endmodule

// File: design/conv3x3_line_buffer_filter_top.sv
// Top level of the 3x3 line-buffer correlation filter over a raster pixel stream.
//
// Usage: pixels of a frame arrive in raster order on the pixels channel, one per
// transaction. The frame size and the three kernel rows are set through the write
// port (cfg_wr_en, cfg_index, cfg_wdata) while no pixel is in flight. For each pixel
// at row >= 2 and column >= 2 one result leaves on the results channel: the 3x3
// correlation of the kernel with the window ending at that pixel, wrapped to the
// pixel width, flagged with row_end on the last result of a row and frame_end on
// the last result of the frame. Pixels in the first two rows or columns give none.
// Throughput: one pixel per clock cycle, sustained while the results channel is not
// stalled. The line store is one memory with one read and one write per cycle, read in
// the accepting cycle and rewritten as the pixel leaves the first stage, which allows
// that rate; a same-column clash is forwarded. A result passes the registered read,
// multiply and sum stages before it is valid on the results channel.
// Reset clears the counters, the window and the registers to their defaults; the
// line store needs no clearing. When the receiver stalls, results back up through
// the pipeline and the pixels channel drops ready only once every stage is full.
`timescale 1ns / 1ps
module conv3x3_line_buffer_filter_top #(
	parameter int MAX_COLS    = c3lbf_pkg::MAX_COLS,
	parameter int PIXEL_WIDTH = c3lbf_pkg::PIXEL_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [c3lbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [c3lbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	c3lbf_pixel_if.sink                      pixels,
	c3lbf_result_if.source                   results
);
	import c3lbf_pkg::*;

	localparam int PW   = PIXEL_WIDTH;
	localparam int CW   = $clog2(MAX_COLS);
	localparam int CMPW = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;
	localparam int PRW  = COEF_BITS + PW;

	// Configuration registers.
	logic [ROWS_W-1:0] frame_rows_q;
	logic [COLS_W-1:0] frame_cols_q;
	logic [KROW_W-1:0] krow_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= FRAME_ROWS_RESET;
			frame_cols_q <= FRAME_COLS_RESET;
			krow_q[0]    <= '0;
			krow_q[1]    <= '0;
			krow_q[2]    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_ROWS:    frame_rows_q <= cfg_wdata[ROWS_W-1:0];
				REG_FRAME_COLS:    frame_cols_q <= cfg_wdata[COLS_W-1:0];
				REG_KERNEL_TOP:    krow_q[0]    <= cfg_wdata[KROW_W-1:0];
				REG_KERNEL_MIDDLE: krow_q[1]    <= cfg_wdata[KROW_W-1:0];
				REG_KERNEL_BOTTOM: krow_q[2]    <= cfg_wdata[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Position of the next pixel and the pipeline handshake.
	logic [CW-1:0]        col_q;
	logic [ROW_CNT_W-1:0] row_q;
	logic [CMPW-1:0]      cols_ext;
	logic [CMPW-1:0]      cols_eff;
	logic [ROWS_W-1:0]    rows_eff;
	logic                 last_col;
	logic                 last_row;
	logic                 has_res;
	logic                 in_acc;
	logic                 in_ready;

	logic                 valid_s1;
	logic signed [PW-1:0] px_s1;
	logic [CW-1:0]        col_s1;
	logic                 res_s1;
	logic                 row_end_s1;
	logic                 frame_end_s1;
	logic                 adv_s1;

	logic                 valid_s2;
	logic [PW-1:0]        prod_s2 [9];
	logic                 row_end_s2;
	logic                 frame_end_s2;
	logic                 free_s2;

	logic                 out_valid_q;
	logic [PW-1:0]        filtered_q;
	logic                 row_end_q;
	logic                 frame_end_q;
	logic                 out_load;

	always_comb begin
		cols_ext = CMPW'(frame_cols_q);
		cols_eff = (cols_ext > CMPW'(MAX_COLS)) ? CMPW'(MAX_COLS) : cols_ext;
		rows_eff = (frame_rows_q > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : frame_rows_q;
		last_col = (CMPW'(col_q) + CMPW'(1)) >= cols_eff;
		last_row = (ROWS_W'(row_q) + ROWS_W'(1)) >= rows_eff;
		has_res  = (row_q >= ROW_CNT_W'(2)) && (col_q >= CW'(2));
	end

	assign out_load = valid_s2 && (!out_valid_q || results.ready);
	assign free_s2  = !valid_s2 || out_load;
	assign adv_s1   = valid_s1 && (!res_s1 || free_s2);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_acc   = pixels.valid && in_ready;
	assign pixels.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_CNT_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1        <= pixels.pixel;
			col_s1       <= col_q;
			res_s1       <= has_res;
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	// Line store word: older row in the upper half, newer row in the lower half.
	logic [2*PW-1:0] ls_rd;

	c3lbf_line_store #(
		.DEPTH (MAX_COLS),
		.WIDTH (2 * PW)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data ({ls_rd[PW-1:0], px_s1}),
		.rd_data (ls_rd)
	);

	// Window columns c-2 (entries 0..2) and c-1 (entries 3..5), top to bottom.
	logic signed [PW-1:0]  win_q    [6];
	logic signed [PW-1:0]  col_new  [3];
	logic signed [PW-1:0]  tap      [9];
	logic signed [PRW-1:0] full_prod [9];
	logic [PW-1:0]         prod     [9];

	always_comb begin
		col_new[0] = ls_rd[2*PW-1:PW];
		col_new[1] = ls_rd[PW-1:0];
		col_new[2] = px_s1;
		for (int i = 0; i < 3; i++) begin
			tap[3*i]     = win_q[i];
			tap[3*i + 1] = win_q[3 + i];
			tap[3*i + 2] = col_new[i];
			for (int j = 0; j < 3; j++) begin
				full_prod[3*i + j] = $signed(krow_q[i][COEF_BITS*j +: COEF_BITS])
					* tap[3*i + j];
				prod[3*i + j] = full_prod[3*i + j][PW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				win_q[k] <= '0;
			end
		end else if (adv_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i]     <= win_q[3 + i];
				win_q[3 + i] <= col_new[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && res_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_load) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_s1) begin
			prod_s2      <= prod;
			row_end_s2   <= row_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	// Nine-term sum; the wrap to the pixel width is the natural overflow.
	logic [PW-1:0] sum;

	always_comb begin
		sum = '0;
		for (int k = 0; k < 9; k++) begin
			sum = sum + prod_s2[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q  <= sum;
			row_end_q   <= row_end_s2;
			frame_end_q <= frame_end_s2;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.filtered  = $signed(filtered_q);
	assign results.row_end   = row_end_q;
	assign results.frame_end = frame_end_q;
endmodule

// File: tb/tb.sv
// Self-checking testbench for the 3x3 line-buffer correlation filter.
`timescale 1ns / 1ps
module tb;
	import c3lbf_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 3'd5;

	typedef struct {
		logic [PIXEL_WIDTH-1:0] filtered;
		logic                   row_end;
		logic                   frame_end;
	} filtered_t;

	class conv_window_scoreboard;
		logic [ROWS_W-1:0]      rows_reg;
		logic [COLS_W-1:0]      cols_reg;
		logic [KROW_W-1:0]      kernel [3];
		logic [PIXEL_WIDTH-1:0] older_line [MAX_COLS];
		logic [PIXEL_WIDTH-1:0] newer_line [MAX_COLS];
		logic [PIXEL_WIDTH-1:0] win [6];
		logic [ROW_CNT_W-1:0]   row_cnt;
		logic [6:0]             col_cnt;
		filtered_t              expected_sums [$];
		int                     errors;

		function new();
			rows_reg = FRAME_ROWS_RESET;
			cols_reg = FRAME_COLS_RESET;
			foreach (kernel[i]) kernel[i] = '0;
			foreach (older_line[i]) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			row_cnt = '0;
			col_cnt = '0;
			errors = 0;
		endfunction

		function int eff_cols();
			int v;
			v = cols_reg;
			if (v < 1) v = 1;
			if (v > MAX_COLS) v = MAX_COLS;
			return v;
		endfunction

		function int eff_rows();
			int v;
			v = rows_reg;
			if (v < 1) v = 1;
			if (v > MAX_ROWS) v = MAX_ROWS;
			return v;
		endfunction

		function int pending();
			return expected_sums.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_FRAME_ROWS: rows_reg = data[ROWS_W-1:0];
			REG_FRAME_COLS: cols_reg = data[COLS_W-1:0];
			REG_KERNEL_TOP: kernel[0] = data[KROW_W-1:0];
			REG_KERNEL_MIDDLE: kernel[1] = data[KROW_W-1:0];
			REG_KERNEL_BOTTOM: kernel[2] = data[KROW_W-1:0];
			default: ;
			endcase
		endfunction

		// Advances the window and line stores by one pixel, queueing any sum it produces.
		function void accept_pixel(logic [PIXEL_WIDTH-1:0] px);
			int c, r;
			bit last_col, last_row;
			logic [PIXEL_WIDTH-1:0] col_new [3];
			logic [PIXEL_WIDTH-1:0] tap;
			logic signed [47:0] acc;
			filtered_t res;
			c = col_cnt;
			r = row_cnt;
			last_col = (c + 1 >= eff_cols());
			last_row = (r + 1 >= eff_rows());
			col_new[0] = older_line[c];
			col_new[1] = newer_line[c];
			col_new[2] = px;
			if (r >= 2 && c >= 2) begin
				acc = '0;
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						if (j == 0) tap = win[i];
						else if (j == 1) tap = win[3 + i];
						else tap = col_new[i];
						acc = acc + $signed(kernel[i][COEF_BITS*j +: COEF_BITS]) * $signed(tap);
					end
				end
				res.filtered = acc[PIXEL_WIDTH-1:0];
				res.row_end = last_col;
				res.frame_end = last_col && last_row;
				expected_sums.push_back(res);
			end
			for (int i = 0; i < 3; i++) begin
				win[i] = win[3 + i];
				win[3 + i] = col_new[i];
			end
			older_line[c] = newer_line[c];
			newer_line[c] = px;
			if (last_col) begin
				col_cnt = '0;
				row_cnt = last_row ? '0 : ROW_CNT_W'(r + 1);
			end else begin
				col_cnt = 7'(c + 1);
			end
		endfunction

		function void report(string what, int expected_v, int actual_v);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
				expected_v, actual_v);
		endfunction

		function void check_result(logic [PIXEL_WIDTH-1:0] filtered, logic row_end,
			logic frame_end);
			filtered_t e;
			if (expected_sums.size() == 0) begin
				report("unexpected result, filtered", 0, $signed(filtered));
				return;
			end
			e = expected_sums.pop_front();
			if (filtered !== e.filtered)
				report("filtered", $signed(e.filtered), $signed(filtered));
			if (row_end !== e.row_end)
				report("row_end", e.row_end, row_end);
			if (frame_end !== e.frame_end)
				report("frame_end", e.frame_end, frame_end);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	c3lbf_pixel_if pix_if();
	c3lbf_result_if res_if();

	conv3x3_line_buffer_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pixels(pix_if),
		.results(res_if)
	);

	conv_window_scoreboard sb = new();
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	bit hold_request = 1'b0;
	int items_sent = 0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.filtered, res_if.row_end, res_if.frame_end);
	end

	// Receiver: random stalls, plus one long hold-off that it counts itself.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [PIXEL_WIDTH-1:0] rand_pixel();
		case ($urandom_range(7))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'h0000;
		3: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [KROW_W-1:0] rand_kernel_row();
		logic [KROW_W-1:0] k;
		k = {16'($urandom), 32'($urandom)};
		for (int j = 0; j < 3; j++) begin
			case ($urandom_range(5))
			0: k[COEF_BITS*j +: COEF_BITS] = 16'h8000;
			1: k[COEF_BITS*j +: COEF_BITS] = 16'h7FFF;
			2: k[COEF_BITS*j +: COEF_BITS] = 16'hFFFF;
			default: ;
			endcase
		end
		return k;
	endfunction

	task automatic set_idle(input int phase);
		case (phase)
		0: begin src_idle_pct = 0; sink_stall_pct = 0; end
		1: begin src_idle_pct = 59; sink_stall_pct = 0; end
		2: begin src_idle_pct = 0; sink_stall_pct = 59; end
		default: begin src_idle_pct = 18; sink_stall_pct = 18; end
		endcase
	endtask

	// All stimulus tasks start and end at a falling edge.
	task automatic send_pixel(input logic [PIXEL_WIDTH-1:0] px);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pixel <= px;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
		sb.accept_pixel(px);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results();
		pix_if.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// Pixels that give no result may still be in the pipeline, so settle past the latency.
	task automatic drain_for_config();
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		sb.write_reg(idx, data);
	endtask

	// Frame sizes go out with random bits above the register width.
	task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int v);
		logic [CFG_DATA_W-1:0] d;
		d = {16'($urandom), 32'($urandom)};
		if (idx == REG_FRAME_ROWS) d[ROWS_W-1:0] = ROWS_W'(v);
		else d[COLS_W-1:0] = COLS_W'(v);
		write_reg(idx, d);
	endtask

	initial begin
		int rows_v, cols_v, n, pause_at;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Smallest frame, all coefficients and pixels at the negative extreme.
		write_size(REG_FRAME_ROWS, 3);
		write_size(REG_FRAME_COLS, 3);
		write_reg(REG_KERNEL_TOP, 48'h8000_8000_8000);
		write_reg(REG_KERNEL_MIDDLE, 48'h8000_8000_8000);
		write_reg(REG_KERNEL_BOTTOM, 48'h8000_8000_8000);
		for (int k = 0; k < 9; k++) send_pixel(16'h8000);
		drain_for_config();

		write_size(REG_FRAME_ROWS, 4);
		write_reg(REG_KERNEL_TOP, 48'h7FFF_8000_FFFF);
		write_reg(REG_KERNEL_MIDDLE, 48'h0001_0000_7FFF);
		write_reg(REG_KERNEL_BOTTOM, 48'h8000_8000_7FFF);
		for (int k = 0; k < 12; k++) begin
			case (k % 5)
			0: send_pixel(16'h7FFF);
			1: send_pixel(16'h8000);
			2: send_pixel(16'h0000);
			3: send_pixel(16'hFFFF);
			default: send_pixel(16'h0001);
			endcase
		end
		drain_for_config();

		// Widest frame: column count above the limit saturates. This also fills both
		// line stores completely, so later size changes never read a stale entry.
		set_idle(0);
		write_size(REG_FRAME_ROWS, 3);
		write_size(REG_FRAME_COLS, 255);
		write_reg(REG_KERNEL_TOP, rand_kernel_row());
		write_reg(REG_KERNEL_MIDDLE, rand_kernel_row());
		write_reg(REG_KERNEL_BOTTOM, rand_kernel_row());
		for (int k = 0; k < 3 * MAX_COLS; k++) begin
			if (k == 300) hold_request = 1'b1;
			if (k == 350) wait_results();
			send_pixel(rand_pixel());
		end
		drain_for_config();

		for (int iter = 0; items_sent < 1150; iter++) begin
			set_idle(iter % 4);
			if ($urandom_range(9) == 0) rows_v = $urandom_range(0, 2);
			else if ($urandom_range(19) == 0) rows_v = $urandom_range(MAX_ROWS + 1, 8191);
			else rows_v = $urandom_range(3, 6);
			if ($urandom_range(9) == 0) cols_v = $urandom_range(0, 2);
			else if ($urandom_range(29) == 0) cols_v = $urandom_range(MAX_COLS + 1, 255);
			else cols_v = $urandom_range(3, 12);
			if ($urandom_range(3) != 0) write_size(REG_FRAME_ROWS, rows_v);
			if ($urandom_range(3) != 0) write_size(REG_FRAME_COLS, cols_v);
			if ($urandom_range(1) == 0) write_reg(REG_KERNEL_TOP, rand_kernel_row());
			if ($urandom_range(1) == 0) write_reg(REG_KERNEL_MIDDLE, rand_kernel_row());
			if ($urandom_range(1) == 0) write_reg(REG_KERNEL_BOTTOM, rand_kernel_row());
			if ($urandom_range(15) == 0)
				write_reg(3'(REG_UNUSED_LOW + $urandom_range(2)),
					{16'($urandom), 32'($urandom)});

			if (sb.eff_rows() < 3 || sb.eff_cols() < 3) n = $urandom_range(4, 16);
			else n = sb.eff_rows() * sb.eff_cols();
			if (n > 200) n = 200;
			// A partial frame leaves the next size change landing mid-frame.
			if ($urandom_range(5) == 0) n = $urandom_range(1, n);
			pause_at = ($urandom_range(7) == 0) ? $urandom_range(0, n - 1) : -1;
			for (int k = 0; k < n; k++) begin
				if (k == pause_at) wait_results();
				send_pixel(rand_pixel());
			end
			drain_for_config();
		end

		wait_results();
		repeat (SETTLE_CYCLES + 2) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
